// ----- rtl/core/gsdm_pkg.sv -----
// ----------------------------------------------------------------------------
// gsdm_pkg
// Shared types and constants for the grey stretch duotone map block.
// ----------------------------------------------------------------------------
package gsdm_pkg;

    localparam int PIX_W     = 8;
    localparam int NUM_CHAN  = 3;
    localparam int CFG_IDX_W = 3;

    // Each map word runs one quotient bit per divider step.
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // floor(sum * 683 / 2048) equals floor(sum / 3) for every sum up to 765.
    localparam int RECIP3_MUL   = 683;
    localparam int RECIP3_SHIFT = 11;

    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_MAP     = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DARK_RED    = 3'd0,
        CFG_DARK_GREEN  = 3'd1,
        CFG_DARK_BLUE   = 3'd2,
        CFG_LIGHT_RED   = 3'd3,
        CFG_LIGHT_GREEN = 3'd4,
        CFG_LIGHT_BLUE  = 3'd5
    } t_cfg_idx;

    localparam logic [PIX_W-1:0] DARK_RESET  = 8'd0;
    localparam logic [PIX_W-1:0] LIGHT_RESET = 8'd255;
    localparam logic [PIX_W-1:0] MIN_RESET   = 8'd255;
    localparam logic [PIX_W-1:0] MAX_RESET   = 8'd0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic calc_grey;
        logic prep;
        logic mul;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_map;
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/core/gsdm_ctrl.sv -----
// ----------------------------------------------------------------------------
// gsdm_ctrl
// Sequencer: accepts a word and steps the datapath through grey and setup;
// map words go on to multiply, the divider iterations and the output load.
// ----------------------------------------------------------------------------
module gsdm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  gsdm_pkg::t_dp_status i_status,
    output gsdm_pkg::t_dp_cmd    o_cmd
);
    import gsdm_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_GREY = 6'b000010,
        S_PREP = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [STEP_W-1:0]  r_step;
    logic               step_last;

    assign step_last = (r_step == STEP_W'(DIV_STEPS - 1));

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_GREY;
                end
            end
            S_GREY: begin
                o_cmd.calc_grey = 1'b1;
                n_state         = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_status.is_map ? S_MUL : S_IDLE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (step_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register can take it.
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DIV) begin
                r_step <= r_step + 1'b1;
            end else begin
                r_step <= '0;
            end
        end
    end

endmodule

// ----- rtl/core/gsdm_datapath.sv -----
// ----------------------------------------------------------------------------
// gsdm_datapath
// Configuration registers, grey level, min/max statistics, three divider
// lanes for the stretch, and the output register.
// ----------------------------------------------------------------------------
module gsdm_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gsdm_pkg::t_dp_cmd            i_cmd_bus,
    output gsdm_pkg::t_dp_status         o_status,
    input  logic                         i_cfg_wr_en,
    input  logic [gsdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gsdm_pkg::PIX_W-1:0]   i_cfg_wdata,
    input  logic                         i_cmd,
    input  logic                         i_first_pixel,
    input  logic [gsdm_pkg::PIX_W-1:0]   i_in_red,
    input  logic [gsdm_pkg::PIX_W-1:0]   i_in_green,
    input  logic [gsdm_pkg::PIX_W-1:0]   i_in_blue,
    input  logic [gsdm_pkg::PIX_W-1:0]   i_in_alpha,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [gsdm_pkg::PIX_W-1:0]   o_out_red,
    output logic [gsdm_pkg::PIX_W-1:0]   o_out_green,
    output logic [gsdm_pkg::PIX_W-1:0]   o_out_blue,
    output logic [gsdm_pkg::PIX_W-1:0]   o_out_alpha
);
    import gsdm_pkg::*;

    localparam int SUM_W  = PIX_W + 2;
    localparam int PROD_W = 2 * PIX_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int REM_W  = PIX_W + 1;
    localparam int RES_W  = PIX_W + 2;

    logic [PIX_W-1:0] r_dark  [NUM_CHAN];
    logic [PIX_W-1:0] r_light [NUM_CHAN];

    logic             r_cmd;
    logic             r_first;
    logic [PIX_W-1:0] r_pix   [NUM_CHAN];
    logic [PIX_W-1:0] r_alpha;
    logic [PIX_W-1:0] r_grey;
    logic [PIX_W-1:0] r_min;
    logic [PIX_W-1:0] r_max;
    logic [PIX_W-1:0] r_n;
    logic [PIX_W-1:0] r_den;
    logic [REM_W-1:0] r_div;
    logic             r_flat;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_chan [NUM_CHAN];
    logic [PIX_W-1:0] r_out_alpha;

    logic [SUM_W-1:0]                   grey_sum;
    logic [SUM_W+RECIP3_SHIFT-1:0]      grey_prod;
    logic [PIX_W-1:0]                   grey_clamped;
    logic [PIX_W-1:0]                   lane_result [NUM_CHAN];

    assign o_status.is_map   = (r_cmd == CMD_MAP);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_dark[c]  <= DARK_RESET;
                r_light[c] <= LIGHT_RESET;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DARK_RED:    r_dark[0]  <= i_cfg_wdata;
                CFG_DARK_GREEN:  r_dark[1]  <= i_cfg_wdata;
                CFG_DARK_BLUE:   r_dark[2]  <= i_cfg_wdata;
                CFG_LIGHT_RED:   r_light[0] <= i_cfg_wdata;
                CFG_LIGHT_GREEN: r_light[1] <= i_cfg_wdata;
                CFG_LIGHT_BLUE:  r_light[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_in) begin
            r_cmd   <= i_cmd;
            r_first <= i_first_pixel;
            r_pix[0] <= i_in_red;
            r_pix[1] <= i_in_green;
            r_pix[2] <= i_in_blue;
            r_alpha <= i_in_alpha;
        end
    end

    // Divide by three through a multiply with the reciprocal.
    assign grey_sum  = SUM_W'(r_pix[0]) + SUM_W'(r_pix[1]) + SUM_W'(r_pix[2]);
    assign grey_prod = (SUM_W + RECIP3_SHIFT)'(grey_sum * RECIP3_MUL);

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.calc_grey) begin
            r_grey <= grey_prod[RECIP3_SHIFT +: PIX_W];
        end
    end

    // A grey outside the measured range maps to the nearest end.
    always_comb begin
        grey_clamped = r_grey;
        if (r_grey < r_min) begin
            grey_clamped = r_min;
        end
        if (r_grey > r_max) begin
            grey_clamped = r_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
            r_max <= MAX_RESET;
        end else if (i_cmd_bus.prep && (r_cmd == CMD_MEASURE)) begin
            if (r_first) begin
                r_min <= r_grey;
                r_max <= r_grey;
            end else begin
                if (r_grey < r_min) begin
                    r_min <= r_grey;
                end
                if (r_grey > r_max) begin
                    r_max <= r_grey;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.prep) begin
            r_flat <= (r_max <= r_min);
            r_n    <= grey_clamped - r_min;
            r_den  <= r_max - r_min;
        end
        if (i_cmd_bus.mul) begin
            r_div <= {r_den, 1'b0};
        end
    end

    // One lane per color channel. The quotient is
    // floor((2|d|n + den - neg) / (2 den)), which is at most |d|, so eight
    // restoring steps settle it; a falling channel subtracts it from dark.
    for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
        logic             r_neg;
        logic [PIX_W-1:0] r_mag;
        logic [REM_W-1:0] r_rem;
        logic [PIX_W-1:0] r_quo;

        logic [PROD_W-1:0] prod;
        logic [NUM_W-1:0]  numer;
        logic [REM_W:0]    trial;
        logic              trial_ge;
        logic [REM_W:0]    trial_diff;
        logic [RES_W-1:0]  sum_ext;

        assign prod       = PROD_W'(r_mag * r_n);
        assign numer      = {prod, 1'b0} + NUM_W'(r_den) - NUM_W'(r_neg);
        assign trial      = {r_rem, r_quo[PIX_W-1]};
        assign trial_ge   = (trial >= {1'b0, r_div});
        assign trial_diff = trial - {1'b0, r_div};

        always_ff @(posedge i_clk) begin
            if (i_cmd_bus.prep) begin
                r_neg <= (r_light[g] < r_dark[g]);
                r_mag <= (r_light[g] < r_dark[g]) ? (r_dark[g] - r_light[g])
                                                  : (r_light[g] - r_dark[g]);
            end
            if (i_cmd_bus.mul) begin
                r_rem <= numer[NUM_W-1:PIX_W];
                r_quo <= numer[PIX_W-1:0];
            end else if (i_cmd_bus.div_step) begin
                r_rem <= trial_ge ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
                r_quo <= {r_quo[PIX_W-2:0], trial_ge};
            end
        end

        assign sum_ext = r_neg ? (RES_W'(r_dark[g]) - RES_W'(r_quo))
                               : (RES_W'(r_dark[g]) + RES_W'(r_quo));

        always_comb begin
            if (r_flat) begin
                lane_result[g] = r_dark[g];
            end else if (sum_ext[RES_W-1]) begin
                lane_result[g] = '0;
            end else if (sum_ext[PIX_W]) begin
                lane_result[g] = '1;
            end else begin
                lane_result[g] = sum_ext[PIX_W-1:0];
            end
        end
    end

    // Output register; the next word is accepted while a result waits here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_bus.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_out) begin
            for (int c = 0; c < NUM_CHAN; c++) begin
                r_out_chan[c] <= lane_result[c];
            end
            r_out_alpha <= r_alpha;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_red   = r_out_chan[0];
    assign o_out_green = r_out_chan[1];
    assign o_out_blue  = r_out_chan[2];
    assign o_out_alpha = r_out_alpha;

endmodule

// ----- rtl/core/grey_stretch_duotone_map_top.sv -----
// ----------------------------------------------------------------------------
// grey_stretch_duotone_map_top
// Two-pass duotone gradient map: measure words track the grey range, map
// words stretch grey between the dark and light colors.
// ----------------------------------------------------------------------------
// A measure word gives no result; a map word passes grey, setup, multiply,
// the 8-step restoring divider and the output load, then shows its result.
// The input stalls until the current word is through, and a map word also
// waits for the output register, so one word is in work at a time.
// Reset (synchronous, active low) clears the sequencer and output valid,
// loads dark 0 / light 255 colors and an empty grey range.
module grey_stretch_duotone_map_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [gsdm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gsdm_pkg::PIX_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_cmd,
    input  logic                           i_first_pixel,
    input  logic [gsdm_pkg::PIX_W-1:0]     i_in_red,
    input  logic [gsdm_pkg::PIX_W-1:0]     i_in_green,
    input  logic [gsdm_pkg::PIX_W-1:0]     i_in_blue,
    input  logic [gsdm_pkg::PIX_W-1:0]     i_in_alpha,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [gsdm_pkg::PIX_W-1:0]     o_out_red,
    output logic [gsdm_pkg::PIX_W-1:0]     o_out_green,
    output logic [gsdm_pkg::PIX_W-1:0]     o_out_blue,
    output logic [gsdm_pkg::PIX_W-1:0]     o_out_alpha
);
    import gsdm_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    gsdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    gsdm_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_bus     (dp_cmd),
        .o_status      (dp_status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (i_cmd),
        .i_first_pixel (i_first_pixel),
        .i_in_red      (i_in_red),
        .i_in_green    (i_in_green),
        .i_in_blue     (i_in_blue),
        .i_in_alpha    (i_in_alpha),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha)
    );

    // The block is busy on the cycle after it takes a word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is still in work");

    // A result is only loaded when the output register can give way.
    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |-> dp_status.out_free)
        else $error("output register overwritten while stalled");

    // The sequencer issues at most one datapath command per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({dp_cmd.load_in, dp_cmd.calc_grey, dp_cmd.prep, dp_cmd.mul,
                  dp_cmd.div_step, dp_cmd.load_out}))
        else $error("more than one datapath command at once");

    // After loading a result the output is valid on the next cycle.
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

endmodule

// ----- dv/grey_stretch_duotone_map_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grey_stretch_duotone_map_top_tb
// Self-checking bench for the duotone map: a short table of directed words,
// then random images (measure pass, then map pass) under several color
// settings and idle patterns. Each mapped word is compared with the table's
// expected word or a predictor tracking the grey range and color registers.
// ----------------------------------------------------------------------------
module grey_stretch_duotone_map_top_tb;

    import gsdm_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic       is_cfg;
        t_cfg_idx   reg_idx;
        logic [7:0] reg_data;
        logic       cmd;
        logic       first;
        t_pixel     pix;
        logic       has_lit;
        t_pixel     lit;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PIX_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_cmd;
    logic                 i_first_pixel;
    logic [PIX_W-1:0]     i_in_red;
    logic [PIX_W-1:0]     i_in_green;
    logic [PIX_W-1:0]     i_in_blue;
    logic [PIX_W-1:0]     i_in_alpha;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [PIX_W-1:0]     o_out_red;
    logic [PIX_W-1:0]     o_out_green;
    logic [PIX_W-1:0]     o_out_blue;
    logic [PIX_W-1:0]     o_out_alpha;

    logic [PIX_W-1:0] color_reg [6];
    logic [PIX_W-1:0] grey_lo;
    logic [PIX_W-1:0] grey_hi;
    t_pixel           mapped_q [$];
    t_row             directed_q [$];
    int               error_count;
    int               tx_idle_pct;
    int               rx_stall_pct;
    logic             rx_hold;
    event             hold_off;

    grey_stretch_duotone_map_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_first_pixel (i_first_pixel),
        .i_in_red      (i_in_red),
        .i_in_green    (i_in_green),
        .i_in_blue     (i_in_blue),
        .i_in_alpha    (i_in_alpha),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_out_alpha   (o_out_alpha)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int grey_level(t_pixel p);
        return (int'(p.red) + int'(p.green) + int'(p.blue)) / 3;
    endfunction

    // Exact dark + (light - dark) * pos / span, rounded half up.
    function automatic logic [7:0] stretch_channel(int dark, int light, int pos, int span);
        int num;
        int den;
        int q;
        int v;
        num = 2 * (light - dark) * pos + span;
        den = 2 * span;
        if (num >= 0) begin
            q = num / den;
        end else begin
            q = -((den - num - 1) / den);
        end
        v = dark + q;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic t_pixel map_pixel(t_pixel p);
        t_pixel res;
        int     g;
        int     lo;
        int     hi;
        lo = int'(grey_lo);
        hi = int'(grey_hi);
        g = grey_level(p);
        res.alpha = p.alpha;
        if (hi <= lo) begin
            res.red   = color_reg[CFG_DARK_RED];
            res.green = color_reg[CFG_DARK_GREEN];
            res.blue  = color_reg[CFG_DARK_BLUE];
        end else begin
            // Grey outside the measured range sits on the nearest end.
            if (g < lo) g = lo;
            if (g > hi) g = hi;
            res.red   = stretch_channel(color_reg[CFG_DARK_RED], color_reg[CFG_LIGHT_RED],
                                        g - lo, hi - lo);
            res.green = stretch_channel(color_reg[CFG_DARK_GREEN],
                                        color_reg[CFG_LIGHT_GREEN], g - lo, hi - lo);
            res.blue  = stretch_channel(color_reg[CFG_DARK_BLUE], color_reg[CFG_LIGHT_BLUE],
                                        g - lo, hi - lo);
        end
        return res;
    endfunction

    function automatic t_row pix_row(logic cmd, logic first, t_pixel p);
        t_row r;
        r = '0;
        r.cmd = cmd;
        r.first = first;
        r.pix = p;
        return r;
    endfunction

    function automatic t_row lit_row(logic first, t_pixel p, t_pixel lit);
        t_row r;
        r = pix_row(CMD_MAP, first, p);
        r.has_lit = 1'b1;
        r.lit = lit;
        return r;
    endfunction

    function automatic t_row cfg_row(t_cfg_idx idx, logic [7:0] data);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic t_pixel rand_pixel(logic narrow, int base);
        int     c [3];
        t_pixel p;
        for (int k = 0; k < 3; k++) begin
            if (narrow) begin
                c[k] = base + $urandom_range(4);
                if (c[k] > 255) c[k] = 255;
            end else if ($urandom_range(7) == 0) begin
                c[k] = ($urandom_range(1) == 1) ? 255 : 0;
            end else begin
                c[k] = $urandom_range(255);
            end
        end
        p.red   = 8'(c[0]);
        p.green = 8'(c[1]);
        p.blue  = 8'(c[2]);
        p.alpha = 8'($urandom_range(255));
        return p;
    endfunction

    task automatic send_word(logic cmd, logic first, t_pixel p, logic has_lit, t_pixel lit);
        int g;
        i_cfg_wr_en   <= 1'b0;
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_first_pixel <= first;
        i_in_red      <= p.red;
        i_in_green    <= p.green;
        i_in_blue     <= p.blue;
        i_in_alpha    <= p.alpha;
        do @(posedge i_clk); while (o_in_stall);
        g = grey_level(p);
        if (cmd == CMD_MAP) begin
            mapped_q.push_back(has_lit ? lit : map_pixel(p));
        end else if (first) begin
            grey_lo = 8'(g);
            grey_hi = 8'(g);
        end else begin
            if (g < int'(grey_lo)) grey_lo = 8'(g);
            if (g > int'(grey_hi)) grey_hi = 8'(g);
        end
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // A measure word gives no result, so the last one may still be in the
    // pipe when the queue runs dry; allow for the map latency on top.
    task automatic wait_idle();
        i_in_valid  <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        while (mapped_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        color_reg[idx] = data;
    endtask

    task automatic set_colors(logic [7:0] dr, logic [7:0] dg, logic [7:0] db,
                              logic [7:0] lr, logic [7:0] lg, logic [7:0] lb);
        write_reg(CFG_DARK_RED, dr);
        write_reg(CFG_DARK_GREEN, dg);
        write_reg(CFG_DARK_BLUE, db);
        write_reg(CFG_LIGHT_RED, lr);
        write_reg(CFG_LIGHT_GREEN, lg);
        write_reg(CFG_LIGHT_BLUE, lb);
    endtask

    // Mostly whole images: a measure pass opened by the first-pixel flag and
    // then a map pass. The rest are loose words with random flags.
    task automatic run_images(int words);
        int   sent;
        int   base;
        int   n_meas;
        int   n_map;
        logic narrow;
        sent = 0;
        while (sent < words) begin
            if ($urandom_range(9) < 8) begin
                narrow = ($urandom_range(3) == 0);
                base = $urandom_range(255);
                n_meas = $urandom_range(1, 12);
                n_map = $urandom_range(1, 12);
                for (int k = 0; k < n_meas; k++) begin
                    send_word(CMD_MEASURE, k == 0, rand_pixel(narrow, base), 1'b0, '0);
                end
                for (int k = 0; k < n_map; k++) begin
                    send_word(CMD_MAP, 1'($urandom_range(1)),
                              rand_pixel(narrow && $urandom_range(3) != 0, base), 1'b0, '0);
                end
                sent += n_meas + n_map;
            end else begin
                send_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                          rand_pixel(1'b0, 0), 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
    end

    initial begin
        rx_hold = 1'b0;
        forever begin
            @(hold_off);
            rx_hold <= 1'b1;
            repeat (400) @(posedge i_clk);
            rx_hold <= 1'b0;
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_out
        t_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mapped_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %0d/%0d/%0d/%0d",
                         $time, o_out_red, o_out_green, o_out_blue, o_out_alpha);
                error_count++;
            end else begin
                want = mapped_q.pop_front();
                check_field("red", want.red, o_out_red);
                check_field("green", want.green, o_out_green);
                check_field("blue", want.blue, o_out_blue);
                check_field("alpha", want.alpha, o_out_alpha);
            end
        end
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_MEASURE;
        i_first_pixel = 1'b0;
        i_in_red      = '0;
        i_in_green    = '0;
        i_in_blue     = '0;
        i_in_alpha    = '0;
        i_out_stall   = 1'b0;
        error_count   = 0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        for (int k = 0; k < 3; k++) begin
            color_reg[k]     = DARK_RESET;
            color_reg[k + 3] = LIGHT_RESET;
        end
        grey_lo = MIN_RESET;
        grey_hi = MAX_RESET;

        // Reset colors: the range is empty, then flat, then full.
        directed_q.push_back(lit_row(1'b0, '{8'h00, 8'h00, 8'h00, 8'hA5},
                                     '{8'h00, 8'h00, 8'h00, 8'hA5}));
        directed_q.push_back(lit_row(1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'h5A},
                                     '{8'h00, 8'h00, 8'h00, 8'h5A}));
        directed_q.push_back(pix_row(CMD_MEASURE, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00}));
        directed_q.push_back(lit_row(1'b0, '{8'h80, 8'h80, 8'h80, 8'h11},
                                     '{8'h00, 8'h00, 8'h00, 8'h11}));
        directed_q.push_back(pix_row(CMD_MEASURE, 1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}));
        directed_q.push_back(lit_row(1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF},
                                     '{8'hFF, 8'hFF, 8'hFF, 8'hFF}));
        directed_q.push_back(lit_row(1'b0, '{8'h00, 8'h00, 8'h00, 8'h00},
                                     '{8'h00, 8'h00, 8'h00, 8'h00}));
        directed_q.push_back(pix_row(CMD_MAP, 1'b0, '{8'h80, 8'h80, 8'h81, 8'h3C}));
        directed_q.push_back(pix_row(CMD_MAP, 1'b1, '{8'h0A, 8'h14, 8'h1E, 8'h77}));
        // Narrow the range to 100..200, then map on both sides of it.
        directed_q.push_back(pix_row(CMD_MEASURE, 1'b1, '{8'h64, 8'h64, 8'h64, 8'h00}));
        directed_q.push_back(pix_row(CMD_MEASURE, 1'b0, '{8'hC8, 8'hC8, 8'hC8, 8'hFF}));
        directed_q.push_back(lit_row(1'b0, '{8'h00, 8'h00, 8'h00, 8'hC3},
                                     '{8'h00, 8'h00, 8'h00, 8'hC3}));
        directed_q.push_back(lit_row(1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'h3C},
                                     '{8'hFF, 8'hFF, 8'hFF, 8'h3C}));
        directed_q.push_back(pix_row(CMD_MAP, 1'b0, '{8'h96, 8'h96, 8'h97, 8'hAA}));
        directed_q.push_back(pix_row(CMD_MEASURE, 1'b0, '{8'hFE, 8'hFF, 8'hFF, 8'h55}));
        directed_q.push_back(pix_row(CMD_MAP, 1'b0, '{8'h01, 8'h01, 8'h02, 8'hAA}));
        // Red and green fall along the ramp (light below dark); blue rises.
        directed_q.push_back(cfg_row(CFG_DARK_RED, 8'hFF));
        directed_q.push_back(cfg_row(CFG_LIGHT_RED, 8'h00));
        directed_q.push_back(cfg_row(CFG_DARK_GREEN, 8'hC8));
        directed_q.push_back(cfg_row(CFG_LIGHT_GREEN, 8'h0A));
        directed_q.push_back(cfg_row(CFG_DARK_BLUE, 8'h40));
        directed_q.push_back(cfg_row(CFG_LIGHT_BLUE, 8'h41));
        directed_q.push_back(lit_row(1'b0, '{8'h00, 8'h00, 8'h00, 8'h01},
                                     '{8'hFF, 8'hC8, 8'h40, 8'h01}));
        directed_q.push_back(lit_row(1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'h02},
                                     '{8'h00, 8'h0A, 8'h41, 8'h02}));
        directed_q.push_back(pix_row(CMD_MAP, 1'b0, '{8'hB4, 8'hAF, 8'hB9, 8'hF0}));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[i]) begin
            if (directed_q[i].is_cfg) begin
                wait_idle();
                write_reg(directed_q[i].reg_idx, directed_q[i].reg_data);
            end else begin
                send_word(directed_q[i].cmd, directed_q[i].first, directed_q[i].pix,
                          directed_q[i].has_lit, directed_q[i].lit);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    set_colors(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    set_colors(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
                    tx_idle_pct = 46;
                    rx_stall_pct = 0;
                end
                2: begin
                    set_colors(8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                    tx_idle_pct = 0;
                    rx_stall_pct = 46;
                end
                3: begin
                    set_colors(8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                    tx_idle_pct = 26;
                    rx_stall_pct = 26;
                end
                4: begin
                    // Equal dark and light colors give a constant output.
                    set_colors(8'h5C, 8'hA3, 8'h17, 8'h5C, 8'hA3, 8'h17);
                    tx_idle_pct = 46;
                    rx_stall_pct = 46;
                end
                default: begin
                    set_colors(8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                    // The sender keeps going while the output is held off,
                    // so the block fills and stalls its input.
                    -> hold_off;
                end
            endcase
            run_images(165);
        end

        i_in_valid <= 1'b0;
        while (mapped_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/gsdm_pkg.sv
rtl/core/gsdm_ctrl.sv
rtl/core/gsdm_datapath.sv
rtl/core/grey_stretch_duotone_map_top.sv
dv/grey_stretch_duotone_map_top_tb.sv
